// ===== rtl/svb_pkg.sv =====
// Shared constants, types and elaboration-time table builders for the sine voice bank.
package svb_pkg;

    localparam int NUM_VOICES       = 4;
    localparam int PHASE_BITS       = 24;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_BITS      = 16;

    localparam int VOICE_W  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int SINE_AW  = $clog2(SINE_TABLE_DEPTH);
    localparam int MODE_W   = 2;
    localparam int NOTE_W   = 7;
    localparam int NUM_NOTES = 2 ** NOTE_W;
    localparam int OUT_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int TERM_W   = 17;
    localparam int ACC_W    = TERM_W + VOICE_W;
    localparam int PROD_W   = SAMPLE_BITS + GAIN_W + 1;
    localparam int SUM_W    = ACC_W + 1;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_PEAK   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_ON   = 2'd1,
        MODE_OFF  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [NOTE_W-1:0]     note;
        logic [NOTE_W-1:0]     level;
        logic [PHASE_BITS-1:0] phase;
        logic [PHASE_BITS-1:0] step;
    } t_voice;

    typedef struct packed {
        logic vld;
        logic last;
    } t_mix_ctl;

    typedef struct packed {
        logic                    done;
        logic signed [ACC_W-1:0] acc;
    } t_mix_res;

    typedef logic [PHASE_BITS-1:0]         t_step_table [NUM_NOTES];
    typedef logic [GAIN_W-1:0]             t_gain_table [NUM_NOTES];
    typedef logic signed [SAMPLE_BITS-1:0] t_sine_table [SINE_TABLE_DEPTH];

    // 2^(r/12) in Q30
    function automatic logic [63:0] semitone_q30(input int r);
        logic [63:0] v;
        unique case (r)
            0:       v = 64'd1073741824;
            1:       v = 64'd1137589835;
            2:       v = 64'd1205234447;
            3:       v = 64'd1276901417;
            4:       v = 64'd1352829926;
            5:       v = 64'd1433273380;
            6:       v = 64'd1518500250;
            7:       v = 64'd1608794974;
            8:       v = 64'd1704458901;
            9:       v = 64'd1805811301;
            10:      v = 64'd1913190429;
            11:      v = 64'd2026954652;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] bv;
        x  = v;
        r  = 64'd0;
        bv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (bv > x) bv = bv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bv != 64'd0) begin
                if (x >= r + bv) begin
                    x = x - (r + bv);
                    r = (r >> 1) + bv;
                end else begin
                    r = r >> 1;
                end
                bv = bv >> 2;
            end
        end
        return r;
    endfunction

    // step = round(55 * 2^((note-69)/12) / 44100 * 2^PHASE_BITS), half up
    function automatic logic [PHASE_BITS-1:0] calc_step(input int note);
        logic [63:0] t;
        logic [63:0] s;
        int u;
        int oct;
        int e;
        int k;
        u   = note + 75;
        oct = u / 12 - 12;
        t   = 64'd55 * semitone_q30(u % 12);
        e   = PHASE_BITS + oct - 30;
        if (e >= 0) begin
            s = ((t << e) + 64'd22050) / 64'd44100;
        end else begin
            k = -e;
            s = ((t + (64'd22050 << k)) / 64'd44100) >> k;
        end
        return s[PHASE_BITS-1:0];
    endfunction

    // Q1.15 gain = (level/127)^0.25 via two floor square roots
    function automatic logic [GAIN_W-1:0] calc_gain(input int level);
        logic [63:0] q;
        logic [63:0] g;
        q = (64'(level) << 56) / 64'd127;
        g = isqrt64(isqrt64(q) * 64'd4);
        return g[GAIN_W-1:0];
    endfunction

    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] calc_sine(input int idx);
        logic [63:0] i4;
        logic [63:0] quad;
        logic [63:0] rem_v;
        logic [63:0] part;
        logic [63:0] ang;
        logic [63:0] s;
        logic [63:0] m;
        i4    = 64'(idx) * 64'd4;
        quad  = i4 / SINE_TABLE_DEPTH;
        rem_v = i4 % SINE_TABLE_DEPTH;
        part  = quad[0] ? (64'(SINE_TABLE_DEPTH) - rem_v) : rem_v;
        ang   = HALF_PI_Q30 * part / SINE_TABLE_DEPTH;
        s     = quarter_sine_q30(ang);
        m     = (s * SINE_PEAK + (64'd1 << 29)) >> 30;
        return (quad >= 64'd2) ? -$signed(m[SAMPLE_BITS-1:0]) : $signed(m[SAMPLE_BITS-1:0]);
    endfunction

    function automatic t_step_table build_step_table();
        t_step_table tbl;
        for (int n = 0; n < NUM_NOTES; n++) tbl[n] = calc_step(n);
        return tbl;
    endfunction

    function automatic t_gain_table build_gain_table();
        t_gain_table tbl;
        for (int n = 0; n < NUM_NOTES; n++) tbl[n] = calc_gain(n);
        return tbl;
    endfunction

    function automatic t_sine_table build_sine_table();
        t_sine_table tbl;
        for (int n = 0; n < SINE_TABLE_DEPTH; n++) tbl[n] = calc_sine(n);
        return tbl;
    endfunction

endpackage

// ===== rtl/svb_voice_ram.sv =====
// Voice state memory: one entry per voice, registered read, valid bits model the zero reset.
module svb_voice_ram
    import svb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [VOICE_W-1:0] i_rd_addr,
    output t_voice             o_rd_data,
    input  logic               i_wr_en,
    input  logic [VOICE_W-1:0] i_wr_addr,
    input  t_voice             i_wr_data
);

    t_voice                  r_mem [NUM_VOICES];
    logic [NUM_VOICES-1:0]   r_valid;
    t_voice                  r_rd_raw;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) r_valid[i_wr_addr] <= 1'b1;
            if (i_rd_en) r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_rd_raw <= r_mem[i_rd_addr];
    end

    // never-written entry reads as reset value
    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && i_wr_en) |-> (i_rd_addr != i_wr_addr))
        else $error("voice ram: read and write of the same entry in one cycle");

endmodule

// ===== rtl/svb_sine_rom.sv =====
// Full-cycle sine ROM with registered read.
module svb_sine_rom
    import svb_pkg::*;
(
    input  logic                          i_clk,
    input  logic [SINE_AW-1:0]            i_addr,
    output logic signed [SAMPLE_BITS-1:0] o_data
);

    localparam t_sine_table SINE_ROM = build_sine_table();

    logic signed [SAMPLE_BITS-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== rtl/svb_mixer.sv =====
// Per-voice gain multiply and mix accumulator.
module svb_mixer
    import svb_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mix_ctl                      i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sine,
    input  logic [GAIN_W-1:0]             i_gain,
    output t_mix_res                      o_res
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p_valid;
    logic                     r_p_last;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    logic signed [TERM_W-1:0] term;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  n_acc;

    // floor(prod / 2^(SAMPLE_BITS-1))
    assign term     = $signed(r_prod[SAMPLE_BITS-1 +: TERM_W]);
    assign acc_base = r_done ? '0 : r_acc;
    assign n_acc    = r_p_valid ? (acc_base + ACC_W'(term)) : acc_base;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_sine * $signed({1'b0, i_gain}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_last  <= 1'b0;
            r_acc     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_p_valid <= i_ctl.vld;
            r_p_last  <= i_ctl.last;
            r_acc     <= n_acc;
            r_done    <= r_p_valid && r_p_last;
        end
    end

    assign o_res.done = r_done;
    assign o_res.acc  = r_acc;

    a_done_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_p_valid)
        else $error("mixer: next tick's term arrived with the previous sum");

endmodule

// ===== rtl/polyphonic_sine_voice_bank.sv =====
// Top level: four-voice sine bank sequencer around the voice memory, sine ROM and mixer.
//
//  channel   direction  handshake             payload
//  input     in         i_valid / o_stall     i_mode, i_note_number, i_note_velocity,
//                                             i_in_left, i_in_right
//  output    out        o_valid / i_stall     o_out_left, o_out_right, o_clipped
//
//  One item is in work at a time. A sample tick walks the voice memory one voice a cycle
//  (single read port). Each voice read passes the ROM, multiply and accumulate stages,
//  and the finished sum passes the saturate-to-staging and output register stages.
//  A note on visits only its allocated slot; a note off visits every voice.
//  Reset (i_rst_n low, synchronous) silences all voices and points the slot at voice 0.
//  A finished tick waits in a staging register while the output register is stalled;
//  input stays open until that staging register is also occupied.
module polyphonic_sine_voice_bank
    import svb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [NOTE_W-1:0]       i_note_number,
    input  logic [NOTE_W-1:0]       i_note_velocity,
    input  logic signed [OUT_W-1:0] i_in_left,
    input  logic signed [OUT_W-1:0] i_in_right,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_out_left,
    output logic signed [OUT_W-1:0] o_out_right,
    output logic                    o_clipped
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // note -> phase increment, velocity -> Q1.15 gain
    localparam t_step_table STEP_TABLE = build_step_table();
    localparam t_gain_table GAIN_TABLE = build_gain_table();

    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(-(2 ** (OUT_W - 1)));
    localparam logic [VOICE_W-1:0]      LAST_VOICE = VOICE_W'(NUM_VOICES - 1);

    // sequencer
    t_state               r_state, n_state;
    logic [VOICE_W-1:0]   r_vidx, n_vidx;
    logic [VOICE_W-1:0]   r_slot;
    t_mode                r_op;
    logic [NOTE_W-1:0]    r_note;
    logic [NOTE_W-1:0]    r_vel;
    logic signed [OUT_W-1:0] r_in_left;
    logic signed [OUT_W-1:0] r_in_right;

    // read/modify/write pipeline
    logic                 r_s1_valid;
    logic                 r_s1_last;
    logic [VOICE_W-1:0]   r_s1_vidx;
    logic                 r_s2_valid;
    logic                 r_s2_last;
    logic [GAIN_W-1:0]    r_gain;

    // result staging and output register
    logic                    r_stage_valid;
    logic signed [OUT_W-1:0] r_stage_left;
    logic signed [OUT_W-1:0] r_stage_right;
    logic                    r_stage_clip;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_left;
    logic signed [OUT_W-1:0] r_out_right;
    logic                    r_out_clip;

    logic                    in_accept;
    logic                    issue;
    logic                    iss_last;
    logic                    out_free;
    t_voice                  rd_data;
    t_voice                  wr_data;
    logic                    wr_en;
    logic signed [SAMPLE_BITS-1:0] sine;
    t_mix_ctl                mix_ctl;
    t_mix_res                mix_res;
    logic signed [SUM_W-1:0] sum_l;
    logic signed [SUM_W-1:0] sum_r;
    logic [OUT_W:0]          sat_l;
    logic [OUT_W:0]          sat_r;

    // {clip, value}
    function automatic logic [OUT_W:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic [OUT_W:0] res;
        priority if (v > SUM_HI) begin
            res = {1'b1, SUM_HI[OUT_W-1:0]};
        end else if (v < SUM_LO) begin
            res = {1'b1, SUM_LO[OUT_W-1:0]};
        end else begin
            res = {1'b0, v[OUT_W-1:0]};
        end
        return res;
    endfunction

    assign o_stall   = (r_state != ST_IDLE) || r_stage_valid;
    assign in_accept = i_valid && !o_stall;
    assign issue     = (r_state == ST_ISSUE);
    // a note on touches only the allocated slot
    assign iss_last  = (r_op == MODE_ON) || (r_vidx == LAST_VOICE);
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_vidx  = r_vidx;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_mode != MODE_NONE)) begin
                    n_state = ST_ISSUE;
                    n_vidx  = (i_mode == MODE_ON) ? r_slot : '0;
                end
            end
            ST_ISSUE: begin
                if (iss_last) n_state = ST_DRAIN;
                else          n_vidx  = r_vidx + 1'b1;
            end
            ST_DRAIN: begin
                // the last note write lands in the first drain cycle; a tick waits for its sum
                if ((r_op != MODE_TICK) || mix_res.done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_vidx        <= '0;
            r_slot        <= '0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_stage_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_vidx     <= n_vidx;
            if (in_accept && (i_mode == MODE_ON)) begin
                r_slot <= (r_slot == LAST_VOICE) ? '0 : r_slot + 1'b1;
            end
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid && (r_op == MODE_TICK);
            if (mix_res.done) begin
                r_stage_valid <= 1'b1;
            end else if (r_stage_valid && out_free) begin
                r_stage_valid <= 1'b0;
            end
            if (r_stage_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op       <= t_mode'(i_mode);
            r_note     <= i_note_number;
            r_vel      <= i_note_velocity;
            r_in_left  <= i_in_left;
            r_in_right <= i_in_right;
        end
        r_s1_last <= iss_last;
        r_s1_vidx <= r_vidx;
        r_s2_last <= r_s1_last;
        r_gain    <= GAIN_TABLE[rd_data.level];
        if (mix_res.done) begin
            r_stage_left  <= $signed(sat_l[OUT_W-1:0]);
            r_stage_right <= $signed(sat_r[OUT_W-1:0]);
            r_stage_clip  <= sat_l[OUT_W] | sat_r[OUT_W];
        end
        if (r_stage_valid && out_free) begin
            r_out_left  <= r_stage_left;
            r_out_right <= r_stage_right;
            r_out_clip  <= r_stage_clip;
        end
    end

    // modify step: entry read last cycle is rewritten now
    always_comb begin
        wr_en   = 1'b0;
        wr_data = rd_data;
        if (r_s1_valid) begin
            unique case (r_op)
                MODE_TICK: begin
                    wr_en         = 1'b1;
                    wr_data.phase = rd_data.phase + rd_data.step;
                end
                MODE_ON: begin
                    // phase is kept on a retrigger
                    wr_en         = 1'b1;
                    wr_data.note  = r_note;
                    wr_data.level = r_vel;
                    wr_data.step  = STEP_TABLE[r_note];
                end
                MODE_OFF: begin
                    if (rd_data.note == r_note) begin
                        wr_en         = 1'b1;
                        wr_data.note  = '0;
                        wr_data.level = '0;
                        wr_data.step  = '0;
                    end
                end
                MODE_NONE: ;
            endcase
        end
    end

    svb_voice_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (issue),
        .i_rd_addr (r_vidx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_vidx),
        .i_wr_data (wr_data)
    );

    // sine of the pre-advance phase
    svb_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rd_data.phase[PHASE_BITS-1 -: SINE_AW]),
        .o_data (sine)
    );

    assign mix_ctl.vld  = r_s2_valid;
    assign mix_ctl.last = r_s2_last;

    svb_mixer u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mix_ctl),
        .i_sine  (sine),
        .i_gain  (r_gain),
        .o_res   (mix_res)
    );

    assign sum_l = SUM_W'(r_in_left)  + SUM_W'(mix_res.acc);
    assign sum_r = SUM_W'(r_in_right) + SUM_W'(mix_res.acc);
    assign sat_l = sat_out(sum_l);
    assign sat_r = sat_out(sum_r);

    assign o_valid     = r_out_valid;
    assign o_out_left  = r_out_left;
    assign o_out_right = r_out_right;
    assign o_clipped   = r_out_clip;

    a_stage_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_res.done |-> !r_stage_valid)
        else $error("tick result would overwrite a waiting result");

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mix_res.done |-> (r_state == ST_DRAIN) && (r_op == MODE_TICK))
        else $error("mix sum finished outside a tick");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1_valid && !r_s2_valid))
        else $error("pipeline busy while sequencer idle");

endmodule
